// ----- hdl/pcc_pkg.sv -----
// ---------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the clamped PID controller
// Widths of the fixed-point datapath, register indexes and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int InW     = 16;               // measured / target / elapsed
    localparam int GainW   = 32;               // Q16.16 gains
    localparam int LimW    = 31;               // clamp magnitudes
    localparam int ErrW    = 17;               // target - measured
    localparam int DerrW   = 18;               // error - previous error
    localparam int ProdW   = GainW + DerrW;    // gain x error products
    localparam int MagW    = 48;               // |kd x derr| fits below 2^48
    localparam int HalfW   = MagW / 2;
    localparam int ScaleW  = 20;
    localparam int CmW     = HalfW + ScaleW;   // half-magnitude x 1e6
    localparam int NumW    = MagW + ScaleW;    // dividend width
    localparam int QuoW    = 52;               // quotient bits developed
    localparam int DivSteps = QuoW / 2;        // two quotient bits a cycle
    localparam int CntW    = $clog2(DivSteps + 1);
    localparam int DMagW   = 51;               // saturated derivative magnitude
    localparam int DW      = DMagW + 1;
    localparam int SumW    = DW + 1;
    localparam int IsumW   = ProdW + 1;

    localparam logic [ScaleW-1:0] UsPerSec = ScaleW'(1000000);
    localparam logic [DMagW-1:0]  DerivCap = DMagW'(1) << (DMagW - 1);

    localparam logic [2:0] REG_KP       = 3'd0;
    localparam logic [2:0] REG_KI       = 3'd1;
    localparam logic [2:0] REG_KD       = 3'd2;
    localparam logic [2:0] REG_INT_LIM  = 3'd3;
    localparam logic [2:0] REG_MAX_OUT  = 3'd4;

    typedef enum logic [1:0] {
        MUL_KP = 2'd0,
        MUL_KI = 2'd1,
        MUL_KD = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     mul_ld;
        logic     p_ld;
        logic     int_upd;
        logic     abs_ld;
        logic     cm_ld;
        logic     cm_hi;
        logic     num_ld;
        logic     div_start;
        logic     d_ld;
        logic     sum_ld;
        logic     out_ld;
    } pcc_cmd_t;

    typedef struct packed {
        logic el_zero;
        logic div_done;
        logic out_free;
    } pcc_sts_t;

endpackage

`default_nettype wire

// ----- hdl/pcc_div.sv -----
// ---------------------------------------------------------------------------
// pcc_div: radix-4 restoring divider for the derivative term
// Divides the scaled magnitude by the elapsed time, two quotient bits per
// cycle, and saturates the quotient at the derivative cap.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pcc_pkg::NumW-1:0]    dividend,
    input  wire logic [pcc_pkg::InW-1:0]     divisor,
    output logic                             done,
    output logic [pcc_pkg::DMagW-1:0]        quotient
);
    import pcc_pkg::*;

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [InW-1:0]  rem_reg, rem_next;
    logic [QuoW-1:0] shf_reg, shf_next;
    logic [InW-1:0]  dvs_reg, dvs_next;
    logic            sat_reg, sat_next;

    logic [InW:0]    t1, t2;
    logic            ge1, ge2;
    logic [InW-1:0]  r1, r2;
    logic [InW-1:0]  top_bits;

    assign top_bits = dividend[NumW-1 -: InW];

    always_comb
    begin
        t1  = {rem_reg, shf_reg[QuoW-1]};
        ge1 = (t1 >= {1'b0, dvs_reg});
        r1  = ge1 ? InW'(t1 - {1'b0, dvs_reg}) : t1[InW-1:0];
        t2  = {r1, shf_reg[QuoW-2]};
        ge2 = (t2 >= {1'b0, dvs_reg});
        r2  = ge2 ? InW'(t2 - {1'b0, dvs_reg}) : t2[InW-1:0];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        dvs_next  = dvs_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            // high bits already at or above the divisor: quotient is at least 2^52
            rem_next  = top_bits;
            sat_next  = (top_bits >= divisor);
            shf_next  = dividend[QuoW-1:0];
            dvs_next  = divisor;
            cnt_next  = CntW'(DivSteps);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = r2;
            shf_next = {shf_reg[QuoW-3:0], ge1, ge2};
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        dvs_reg <= dvs_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;

    always_comb
    begin
        if (sat_reg || (shf_reg > QuoW'(DerivCap)))
            quotient = DerivCap;
        else
            quotient = shf_reg[DMagW-1:0];
    end

endmodule

`default_nettype wire

// ----- hdl/pcc_dpath.sv -----
// ---------------------------------------------------------------------------
// pcc_dpath: PID datapath
// Gain registers, shared gain multiplier, integral accumulator with clamp,
// derivative scaling and division, output sum with clamp and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pcc_pkg::pcc_cmd_t                  cmd,
    output pcc_pkg::pcc_sts_t                       sts,
    input  wire logic signed [pcc_pkg::InW-1:0]     measured,
    input  wire logic signed [pcc_pkg::InW-1:0]     target,
    input  wire logic [pcc_pkg::InW-1:0]            elapsed_us,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [pcc_pkg::GainW-1:0]          cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [pcc_pkg::GainW-1:0]        drive,
    output logic                                    integral_clamped,
    output logic                                    output_clamped
);
    import pcc_pkg::*;

    // configuration and loop state
    logic signed [GainW-1:0] kp_reg, kp_next;
    logic signed [GainW-1:0] ki_reg, ki_next;
    logic signed [GainW-1:0] kd_reg, kd_next;
    logic [LimW-1:0]         ilim_reg, ilim_next;
    logic [LimW-1:0]         mout_reg, mout_next;
    logic signed [GainW-1:0] isum_reg, isum_next;
    logic signed [ErrW-1:0]  prev_reg, prev_next;
    logic                    ihit_reg, ihit_next;
    logic                    ovalid_reg, ovalid_next;

    // working registers
    logic signed [ErrW-1:0]  err_reg;
    logic signed [DerrW-1:0] derr_reg;
    logic [InW-1:0]          el_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [ProdW-1:0] p_reg;
    logic [MagW-1:0]         mag_reg;
    logic                    neg_reg;
    logic [CmW-1:0]          lo_reg;
    logic [CmW-1:0]          hi_reg;
    logic [NumW-1:0]         num_reg;
    logic signed [DW-1:0]    d_reg;
    logic signed [SumW-1:0]  sum_reg;
    logic signed [GainW-1:0] drive_reg;
    logic                    iclamp_reg;
    logic                    oclamp_reg;

    logic                    cfg_hit;
    logic signed [ErrW-1:0]  err_new;
    logic signed [DerrW-1:0] derr_new;
    logic signed [GainW-1:0] mul_a;
    logic signed [DerrW-1:0] mul_b;
    logic signed [ProdW-1:0] mul_p;
    logic signed [IsumW-1:0] isum_w;
    logic signed [IsumW-1:0] ilim_pos;
    logic signed [IsumW-1:0] ilim_neg;
    logic signed [GainW-1:0] isum_clamped;
    logic                    isum_hit;
    logic signed [ProdW-1:0] prod_neg;
    logic [HalfW-1:0]        cm_in;
    logic [CmW-1:0]          cm_p;
    logic [DMagW-1:0]        dmag;
    logic                    div_done;
    logic signed [SumW-1:0]  mout_pos;
    logic signed [SumW-1:0]  mout_neg;
    logic signed [GainW-1:0] drive_new;
    logic                    ohit;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_hit   = 1'b0;
        kp_next   = kp_reg;
        ki_next   = ki_reg;
        kd_next   = kd_reg;
        ilim_next = ilim_reg;
        mout_next = mout_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP:      begin kp_next   = cfg_data;              cfg_hit = 1'b1; end
                REG_KI:      begin ki_next   = cfg_data;              cfg_hit = 1'b1; end
                REG_KD:      begin kd_next   = cfg_data;              cfg_hit = 1'b1; end
                REG_INT_LIM: begin ilim_next = cfg_data[LimW-1:0];    cfg_hit = 1'b1; end
                REG_MAX_OUT: begin mout_next = cfg_data[LimW-1:0];    cfg_hit = 1'b1; end
                default:     cfg_hit = 1'b0;
            endcase
        end
    end

    assign err_new  = {target[InW-1], target} - {measured[InW-1], measured};
    assign derr_new = {err_new[ErrW-1], err_new} - {prev_reg[ErrW-1], prev_reg};

    // shared gain multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_KP:
            begin
                mul_a = kp_reg;
                mul_b = {err_reg[ErrW-1], err_reg};
            end
            MUL_KI:
            begin
                mul_a = ki_reg;
                mul_b = {err_reg[ErrW-1], err_reg};
            end
            MUL_KD:
            begin
                mul_a = kd_reg;
                mul_b = derr_reg;
            end
            default:
            begin
                mul_a = kp_reg;
                mul_b = {err_reg[ErrW-1], err_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // integral update against its clamp; prod_reg holds ki x error here
    always_comb
    begin
        isum_w   = {{(IsumW-GainW){isum_reg[GainW-1]}}, isum_reg}
                 + {prod_reg[ProdW-1], prod_reg};
        ilim_pos = {{(IsumW-LimW){1'b0}}, ilim_reg};
        ilim_neg = -ilim_pos;
        if (isum_w > ilim_pos)
        begin
            isum_clamped = ilim_pos[GainW-1:0];
            isum_hit     = 1'b1;
        end
        else if (isum_w < ilim_neg)
        begin
            isum_clamped = ilim_neg[GainW-1:0];
            isum_hit     = 1'b1;
        end
        else
        begin
            isum_clamped = isum_w[GainW-1:0];
            isum_hit     = 1'b0;
        end
    end

    always_comb
    begin
        isum_next = isum_reg;
        prev_next = prev_reg;
        ihit_next = ihit_reg;
        if (cfg_hit)
        begin
            isum_next = '0;
            prev_next = '0;
        end
        else
        begin
            if (cmd.capture)
                prev_next = err_new;
            if (cmd.int_upd)
            begin
                isum_next = isum_clamped;
                ihit_next = isum_hit;
            end
        end
    end

    assign prod_neg = -prod_reg;

    // magnitude x 1e6 in two halves through one multiplier
    assign cm_in = cmd.cm_hi ? mag_reg[MagW-1:HalfW] : mag_reg[HalfW-1:0];
    assign cm_p  = CmW'(cm_in) * CmW'(UsPerSec);

    pcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (el_reg),
        .done     (div_done),
        .quotient (dmag)
    );

    // output clamp
    always_comb
    begin
        mout_pos = {{(SumW-LimW){1'b0}}, mout_reg};
        mout_neg = -mout_pos;
        if (sum_reg > mout_pos)
        begin
            drive_new = mout_pos[GainW-1:0];
            ohit      = 1'b1;
        end
        else if (sum_reg < mout_neg)
        begin
            drive_new = mout_neg[GainW-1:0];
            ohit      = 1'b1;
        end
        else
        begin
            drive_new = sum_reg[GainW-1:0];
            ohit      = 1'b0;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_ld)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            ilim_reg   <= '0;
            mout_reg   <= '0;
            isum_reg   <= '0;
            prev_reg   <= '0;
            ihit_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            kp_reg     <= kp_next;
            ki_reg     <= ki_next;
            kd_reg     <= kd_next;
            ilim_reg   <= ilim_next;
            mout_reg   <= mout_next;
            isum_reg   <= isum_next;
            prev_reg   <= prev_next;
            ihit_reg   <= ihit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            err_reg  <= err_new;
            derr_reg <= derr_new;
            el_reg   <= elapsed_us;
        end
        if (cmd.mul_ld)
            prod_reg <= mul_p;
        if (cmd.p_ld)
            p_reg <= prod_reg;
        if (cmd.abs_ld)
        begin
            neg_reg <= prod_reg[ProdW-1];
            mag_reg <= prod_reg[ProdW-1] ? prod_neg[MagW-1:0] : prod_reg[MagW-1:0];
            d_reg   <= '0;
        end
        if (cmd.cm_ld)
        begin
            if (cmd.cm_hi)
                hi_reg <= cm_p;
            else
                lo_reg <= cm_p;
        end
        if (cmd.num_ld)
            num_reg <= {hi_reg, {HalfW{1'b0}}} + {{HalfW{1'b0}}, lo_reg};
        if (cmd.d_ld)
            d_reg <= neg_reg ? -{1'b0, dmag} : {1'b0, dmag};
        if (cmd.sum_ld)
            sum_reg <= {{(SumW-ProdW){p_reg[ProdW-1]}}, p_reg}
                     + {{(SumW-GainW){isum_reg[GainW-1]}}, isum_reg}
                     + {d_reg[DW-1], d_reg};
        if (cmd.out_ld)
        begin
            drive_reg  <= drive_new;
            iclamp_reg <= ihit_reg;
            oclamp_reg <= ohit;
        end
    end

    assign sts.el_zero  = (el_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !ovalid_reg || out_ready;

    assign out_valid        = ovalid_reg;
    assign drive            = drive_reg;
    assign integral_clamped = iclamp_reg;
    assign output_clamped   = oclamp_reg;

endmodule

`default_nettype wire

// ----- hdl/pcc_ctrl.sv -----
// ---------------------------------------------------------------------------
// pcc_ctrl: PID sequencer
// One-hot state machine that steps the datapath through the three terms,
// the derivative division (skipped when elapsed is zero) and the output stage per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output pcc_pkg::pcc_cmd_t       cmd,
    input  wire pcc_pkg::pcc_sts_t  sts
);
    import pcc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_MP   = 13'b0000000000010,
        S_MI   = 13'b0000000000100,
        S_MD   = 13'b0000000001000,
        S_ABS  = 13'b0000000010000,
        S_CLO  = 13'b0000000100000,
        S_CHI  = 13'b0000001000000,
        S_NSUM = 13'b0000010000000,
        S_DLD  = 13'b0000100000000,
        S_DIV  = 13'b0001000000000,
        S_DFIN = 13'b0010000000000,
        S_SUM  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_KP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MP;
                end
            end
            S_MP:
            begin
                cmd.mul_sel = MUL_KP;
                cmd.mul_ld  = 1'b1;
                state_next  = S_MI;
            end
            S_MI:
            begin
                cmd.mul_sel = MUL_KI;
                cmd.mul_ld  = 1'b1;
                cmd.p_ld    = 1'b1;
                state_next  = S_MD;
            end
            S_MD:
            begin
                // integral takes ki x error while kd x derr is formed
                cmd.mul_sel = MUL_KD;
                cmd.mul_ld  = 1'b1;
                cmd.int_upd = 1'b1;
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_ld = 1'b1;
                state_next = sts.el_zero ? S_SUM : S_CLO;
            end
            S_CLO:
            begin
                cmd.cm_ld  = 1'b1;
                state_next = S_CHI;
            end
            S_CHI:
            begin
                cmd.cm_ld  = 1'b1;
                cmd.cm_hi  = 1'b1;
                state_next = S_NSUM;
            end
            S_NSUM:
            begin
                cmd.num_ld = 1'b1;
                state_next = S_DLD;
            end
            S_DLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.d_ld   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_ld = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- hdl/pid_controller_clamped_top.sv -----
// One input transaction is processed at a time: in_ready is high only while the
// sequencer is idle. The derivative divider, which retires two quotient bits a
// cycle, is skipped when elapsed_us is 0.
// A finished result waits in the output register while the next input is taken.
// Reset (rst_n, asynchronous) clears gains, limits, integral sum and last error.
// ---------------------------------------------------------------------------
// pid_controller_clamped_top: positional PID controller with integral clamp
// Q16.16 PID with clamped integral and output; configuration on its own port.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [pcc_pkg::InW-1:0]     measured,
    input  wire logic signed [pcc_pkg::InW-1:0]     target,
    input  wire logic [pcc_pkg::InW-1:0]            elapsed_us,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [pcc_pkg::GainW-1:0]        drive,
    output logic                                    integral_clamped,
    output logic                                    output_clamped,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [pcc_pkg::GainW-1:0]          cfg_data
);
    import pcc_pkg::*;

    pcc_cmd_t cmd;
    pcc_sts_t sts;

    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pcc_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .measured         (measured),
        .target           (target),
        .elapsed_us       (elapsed_us),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive            (drive),
        .integral_clamped (integral_clamped),
        .output_clamped   (output_clamped)
    );

endmodule

`default_nettype wire

// ----- tb/sv/pid_controller_clamped_checker.sv -----
// ---------------------------------------------------------------------------
// pid_controller_clamped_checker: result checker for the clamped PID block
// Watches the input, result and register-write channels, keeps its own copy
// of gains, limits, accumulator and last error, works out the expected drive
// and clamp flags for each input transaction and compares them in order.
// ---------------------------------------------------------------------------

module pid_controller_clamped_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [pcc_pkg::InW-1:0]   measured,
    input  logic signed [pcc_pkg::InW-1:0]   target,
    input  logic [pcc_pkg::InW-1:0]          elapsed_us,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [pcc_pkg::GainW-1:0] drive,
    input  logic                             integral_clamped,
    input  logic                             output_clamped,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [pcc_pkg::GainW-1:0]        cfg_data,
    output int                               mismatches,
    output int                               pending
);
    import pcc_pkg::*;

    typedef struct packed {
        logic signed [GainW-1:0] drive;
        logic                    integral_clamped;
        logic                    output_clamped;
    } pid_result_t;

    localparam longint unsigned UsPerSecond = 64'd1000000;
    localparam longint unsigned DerivSat    = 64'd1 << 50;
    localparam longint unsigned QuoCeiling  = 64'd1 << 34;

    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         lim_int;
    logic [LimW-1:0]         lim_out;
    longint                  accum;
    longint                  prev_err;

    pid_result_t             expected_drives[$];
    int                      mismatch_total = 0;

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic pid_result_t compute_drive(input logic signed [InW-1:0] meas,
                                                  input logic signed [InW-1:0] tgt,
                                                  input logic [InW-1:0]        el);
        longint          err;
        longint          ilim;
        longint          olim;
        longint          p_term;
        longint          d_term;
        longint          prod;
        longint          sum;
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned res;
        pid_result_t     r;

        err  = longint'(tgt) - longint'(meas);
        ilim = longint'({1'b0, lim_int});
        olim = longint'({1'b0, lim_out});

        p_term = longint'(gain_p) * err;

        accum = accum + longint'(gain_i) * err;
        r.integral_clamped = 1'b0;
        if (accum > ilim)
        begin
            accum = ilim;
            r.integral_clamped = 1'b1;
        end
        else if (accum < -ilim)
        begin
            accum = -ilim;
            r.integral_clamped = 1'b1;
        end

        // derivative: truncate the magnitude, then restore the sign
        d_term = 0;
        if (el != '0)
        begin
            prod = longint'(gain_d) * (err - prev_err);
            mag  = (prod < 0) ? -prod : prod;
            quo  = mag / el;
            rem  = mag % el;
            if (quo > QuoCeiling)
                res = DerivSat;
            else
            begin
                res = quo * UsPerSecond + (rem * UsPerSecond) / el;
                if (res > DerivSat)
                    res = DerivSat;
            end
            d_term = (prod < 0) ? -longint'(res) : longint'(res);
        end

        sum = p_term + accum + d_term;
        r.output_clamped = 1'b0;
        if (sum > olim)
        begin
            sum = olim;
            r.output_clamped = 1'b1;
        end
        else if (sum < -olim)
        begin
            sum = -olim;
            r.output_clamped = 1'b1;
        end
        r.drive = sum[GainW-1:0];

        prev_err = err;
        return r;
    endfunction

    always @(posedge clk)
    begin
        pid_result_t exp_r;

        if (!rst_n)
        begin
            gain_p   = '0;
            gain_i   = '0;
            gain_d   = '0;
            lim_int  = '0;
            lim_out  = '0;
            accum    = 0;
            prev_err = 0;
            expected_drives.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KP:      gain_p  = cfg_data;
                    REG_KI:      gain_i  = cfg_data;
                    REG_KD:      gain_d  = cfg_data;
                    REG_INT_LIM: lim_int = cfg_data[LimW-1:0];
                    REG_MAX_OUT: lim_out = cfg_data[LimW-1:0];
                    default:     ;
                endcase
                // unknown indexes leave the loop state alone
                if (cfg_index <= REG_MAX_OUT)
                begin
                    accum    = 0;
                    prev_err = 0;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_drives.size() == 0)
                    flag_mismatch("result transaction with nothing expected");
                else
                begin
                    exp_r = expected_drives.pop_front();
                    if (drive !== exp_r.drive)
                        flag_mismatch($sformatf("drive got %0d exp %0d",
                                                drive, exp_r.drive));
                    if (integral_clamped !== exp_r.integral_clamped)
                        flag_mismatch($sformatf("integral_clamped got %b exp %b",
                                                integral_clamped, exp_r.integral_clamped));
                    if (output_clamped !== exp_r.output_clamped)
                        flag_mismatch($sformatf("output_clamped got %b exp %b",
                                                output_clamped, exp_r.output_clamped));
                end
            end

            if (in_valid && in_ready)
                expected_drives.push_back(compute_drive(measured, target, elapsed_us));
        end

        mismatches <= mismatch_total;
        pending    <= expected_drives.size();
    end

endmodule

// ----- tb/sv/pid_controller_clamped_top_test.sv -----
// ---------------------------------------------------------------------------
// pid_controller_clamped_top_test: stimulus and verdict for the PID block
// Directed transactions over extreme gains, limits and inputs, then random
// register settings and input sequences with random idling on both sides.
// ---------------------------------------------------------------------------

module pid_controller_clamped_top_test;
    import pcc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int TailCycles    = 60;
    localparam int RandPhases    = 8;
    localparam int PhaseItems    = 50;
    localparam int IdlePercent   = 7;
    localparam logic [2:0] RegCodeLast = 3'd7;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [InW-1:0]   measured;
    logic signed [InW-1:0]   target;
    logic [InW-1:0]          elapsed_us;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [GainW-1:0] drive;
    logic                    integral_clamped;
    logic                    output_clamped;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [GainW-1:0]        cfg_data;

    int                      mismatches;
    int                      pending;
    int                      stall_cycles = 0;
    bit                      quiet = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pid_controller_clamped_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .measured         (measured),
        .target           (target),
        .elapsed_us       (elapsed_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive            (drive),
        .integral_clamped (integral_clamped),
        .output_clamped   (output_clamped),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pid_controller_clamped_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .measured         (measured),
        .target           (target),
        .elapsed_us       (elapsed_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive            (drive),
        .integral_clamped (integral_clamped),
        .output_clamped   (output_clamped),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    // result back-pressure
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= IdlePercent);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == WatchdogLimit)
        begin
            $display("pid_controller_clamped_top_test: FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_sample(input logic signed [InW-1:0] m,
                               input logic signed [InW-1:0] t,
                               input logic [InW-1:0]        e);
        // register writes stop before any input transaction is offered
        cfg_valid <= 1'b0;
        while (!quiet && $urandom_range(0, 99) < IdlePercent)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        measured   <= m;
        target     <= t;
        elapsed_us <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [GainW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [InW-1:0] m;
        logic signed [InW-1:0] t;
        logic [InW-1:0]        e;
        logic [GainW-1:0]      v;
        int                    quiet_phase;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        measured   <= '0;
        target     <= '0;
        elapsed_us <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_KP;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: everything zero, drive held at zero
        send_sample(16'sd100, -16'sd100, 16'd10);
        send_sample(-16'sd32768, 16'sd32767, 16'd0);
        drain();

        // values landing exactly on a limit must not raise the flags; the second sample goes past the integral limit
        write_reg(REG_KP, 32'h0000_0000);
        write_reg(REG_KI, 32'h0001_0000);
        write_reg(REG_KD, 32'h0000_0000);
        write_reg(REG_INT_LIM, 32'h0005_0000);
        write_reg(REG_MAX_OUT, 32'h0005_0000);
        send_sample(16'sd0, 16'sd5, 16'd10);
        send_sample(16'sd0, 16'sd1, 16'd10);
        drain();
        // unknown indexes: accumulator must survive
        write_reg(REG_MAX_OUT + 3'd1, 32'hFFFF_FFFF);
        write_reg(RegCodeLast, 32'h1234_5678);
        send_sample(16'sd0, -16'sd2, 16'd10);
        drain();

        // extreme gains, derivative saturation
        write_reg(REG_KP, 32'h8000_0000);
        write_reg(REG_KI, 32'h7FFF_FFFF);
        write_reg(REG_KD, 32'h8000_0000);
        write_reg(REG_INT_LIM, 32'hFFFF_FFFF);
        write_reg(REG_MAX_OUT, 32'h7FFF_FFFF);
        send_sample(-16'sd32768, 16'sd32767, 16'd1);
        send_sample(16'sd32767, -16'sd32768, 16'd1);
        send_sample(-16'sd32768, 16'sd32767, 16'd0);
        send_sample(16'sd0, 16'sd0, 16'd65535);
        send_sample(16'sd32767, 16'sd32767, 16'd65535);
        send_sample(-16'sd1, 16'sd0, 16'd3);
        drain();

        // zero limits
        write_reg(REG_KP, 32'h0001_0000);
        write_reg(REG_KI, 32'h0001_0000);
        write_reg(REG_KD, 32'h7FFF_FFFF);
        write_reg(REG_INT_LIM, 32'h0000_0000);
        write_reg(REG_MAX_OUT, 32'h0000_0000);
        send_sample(16'sd0, 16'sd1000, 16'd7);
        send_sample(16'sd5, -16'sd5, 16'd0);
        send_sample(-16'sd32768, 16'sd32767, 16'd1);
        drain();

        // moderate settings, outputs mostly inside the clamps
        write_reg(REG_KP, 32'h0001_8000);
        write_reg(REG_KI, 32'hFFFF_C000);
        write_reg(REG_KD, 32'h0000_0200);
        write_reg(REG_INT_LIM, 32'h0064_0000);
        write_reg(REG_MAX_OUT, 32'h4000_0000);
        send_sample(16'sd10, 16'sd20, 16'd1000);
        send_sample(16'sd12, 16'sd20, 16'd999);
        send_sample(16'sd20, 16'sd20, 16'd65535);
        send_sample(16'sd25, 16'sd20, 16'd1);
        send_sample(16'sd30, -16'sd30, 16'd0);
        drain();

        quiet_phase = $urandom_range(0, RandPhases - 1);
        for (int ph = 0; ph < RandPhases; ph++)
        begin
            quiet = (ph == quiet_phase);
            for (int r = REG_KP; r <= REG_MAX_OUT; r++)
            begin
                if (ph != 0 && $urandom_range(0, 4) == 0)
                    continue;
                if (r < REG_INT_LIM)
                begin
                    case ($urandom_range(0, 3))
                        0:       v = $urandom;
                        3:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        default: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       v = $urandom;
                        1:       v = 32'h0000_0000;
                        2:       v = 32'h7FFF_FFFF;
                        default: v = $urandom_range(0, 32'h0100_0000);
                    endcase
                end
                write_reg(r[2:0], v);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(3'($urandom_range(REG_MAX_OUT + 1, RegCodeLast)), $urandom);

            for (int n = 0; n < PhaseItems; n++)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        m = 16'($urandom);
                        t = 16'($urandom);
                    end
                    3:
                    begin
                        m = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                        t = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                    end
                    default:
                    begin
                        // setpoint tracking: small error around a random level
                        m = 16'($urandom);
                        t = 16'(m + $urandom_range(0, 400) - 200);
                    end
                endcase
                case ($urandom_range(0, 9))
                    0:       e = '0;
                    1, 2:    e = 16'($urandom_range(1, 100));
                    3, 4, 5: e = 16'($urandom_range(900, 2100));
                    default: e = 16'($urandom);
                endcase
                send_sample(m, t, e);
            end
            drain();
        end
        quiet = 1'b0;

        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("pid_controller_clamped_top_test: PASS");
        else
            $display("pid_controller_clamped_top_test: FAIL");
        $finish;
    end

endmodule
